// ===== rtl/bdrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdrs_pkg
// Shared codes and default sizes for the boxcar DAC ramp sequencer.
// ----------------------------------------------------------------------------
package bdrs_pkg;

    localparam int LEVEL_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int RAMP_INDEX_BITS = 16;
    localparam int CFG_INDEX_BITS  = 3;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_RUNNING  = 3'd0,
        ST_DONE     = 3'd1,
        ST_STOPPED  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_IDLE     = 3'd4
    } t_status;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAMP_POINTS = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MEASURES    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AVERAGES    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_START   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_STEP    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_START  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_STEP   = 3'd6;

endpackage
`default_nettype wire

// ===== rtl/boxcar_dac_ramp_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boxcar_dac_ramp_sequencer
// Steps one DAC channel through alternating low/high boxcar ramp levels.
// ----------------------------------------------------------------------------
// Usage:
//   Command words (start, ADC frame done, stop) enter on the i_in_valid /
//   o_in_ready channel. Every accepted word yields exactly one result word on
//   o_out_valid / i_out_ready carrying the latch flag, the level now on the
//   DAC, its ramp index, its set (low/high) and the run status.
//   The result of a word accepted at one edge is valid after that edge.
//   Throughput is one word per cycle while i_out_ready holds; the counters,
//   the two ramp adders and the level select all settle between the input
//   handshake and the result register.
//   The result register doubles as the skid stage: a new word is taken while
//   a result is waiting, as long as that result leaves in the same cycle.
//   When the receiver stalls, o_in_ready drops and the held result stays put.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data with
//   no handshake, while no word is in flight.
//   Reset (synchronous, active low) clears the run state, empties the result
//   register and loads the register defaults: counts of one, levels of zero.
// ----------------------------------------------------------------------------
module boxcar_dac_ramp_sequencer #(
    parameter int LEVEL_BITS = bdrs_pkg::LEVEL_BITS_DEF,
    parameter int COUNT_BITS = bdrs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    // configuration
    input  wire logic                                    i_cfg_we,
    input  wire logic [bdrs_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  wire logic [(LEVEL_BITS > COUNT_BITS ? LEVEL_BITS : COUNT_BITS)-1:0] i_cfg_data,
    // command channel
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_ready,
    input  wire logic [1:0]                              i_cmd,
    input  wire logic                                    i_frame_rejected,
    // result channel
    output logic                                         o_out_valid,
    input  wire logic                                    i_out_ready,
    output logic                                         o_latch,
    output logic signed [LEVEL_BITS-1:0]                 o_level,
    output logic [bdrs_pkg::RAMP_INDEX_BITS-1:0]         o_ramp_index,
    output logic                                         o_is_high,
    output logic [2:0]                                   o_status
);

    localparam int RIW = bdrs_pkg::RAMP_INDEX_BITS;
    localparam int PW  = COUNT_BITS + 1;

    // configuration registers
    logic [COUNT_BITS-1:0] r_ramp_points;
    logic [COUNT_BITS-1:0] r_measures;
    logic [COUNT_BITS-1:0] r_averages;
    logic [LEVEL_BITS-1:0] r_low_start;
    logic [LEVEL_BITS-1:0] r_low_step;
    logic [LEVEL_BITS-1:0] r_high_start;
    logic [LEVEL_BITS-1:0] r_high_step;

    // run state
    logic                  r_running,     n_running;
    logic [COUNT_BITS-1:0] r_samples,     n_samples;
    logic [PW-1:0]         r_phase,       n_phase;
    logic [COUNT_BITS-1:0] r_point,       n_point;
    logic [LEVEL_BITS-1:0] r_low_acc,     n_low_acc;
    logic [LEVEL_BITS-1:0] r_high_acc,    n_high_acc;
    logic [LEVEL_BITS-1:0] r_level_q,     n_level_q;
    logic                  r_latched_high, n_latched_high;

    // result register
    logic                  r_out_valid;
    logic                  r_latch,       n_latch;
    logic [LEVEL_BITS-1:0] r_level;
    logic [RIW-1:0]        r_ramp_index;
    logic                  r_is_high;
    logic [2:0]            r_status;
    bdrs_pkg::t_status     n_status;

    logic                  w_in_fire;

    // frame step arithmetic
    logic [COUNT_BITS-1:0] w_mps;
    logic [COUNT_BITS-1:0] w_pts;
    logic [COUNT_BITS-1:0] w_avg;
    logic [PW-1:0]         w_pair_len;
    logic [PW-1:0]         w_count;
    logic [PW-1:0]         w_point_inc;
    logic [PW:0]           w_phase_inc;
    logic                  w_step_open;
    logic                  w_pair_end;
    logic                  w_last_step;
    logic [PW-1:0]         w_phase_adv;
    logic [LEVEL_BITS-1:0] w_low_adv;
    logic [LEVEL_BITS-1:0] w_high_adv;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // zero counts behave as one
    assign w_mps = (r_measures    == '0) ? COUNT_BITS'(1) : r_measures;
    assign w_pts = (r_ramp_points == '0) ? COUNT_BITS'(1) : r_ramp_points;
    assign w_avg = (r_averages    == '0) ? COUNT_BITS'(1) : r_averages;
    assign w_pair_len = {w_avg, 1'b0};

    assign w_count     = {1'b0, r_samples} + PW'(1);
    assign w_point_inc = {1'b0, r_point} + PW'(1);
    assign w_phase_inc = {1'b0, r_phase} + (PW+1)'(1);

    assign w_step_open = w_count < {1'b0, w_mps};
    assign w_pair_end  = w_phase_inc >= {1'b0, w_pair_len};
    assign w_last_step = (w_point_inc >= {1'b0, w_pts}) && w_pair_end;

    assign w_phase_adv = w_pair_end ? '0 : w_phase_inc[PW-1:0];
    assign w_low_adv   = w_pair_end ? r_low_acc + r_low_step   : r_low_acc;
    assign w_high_adv  = w_pair_end ? r_high_acc + r_high_step : r_high_acc;

    always_comb begin
        n_running      = r_running;
        n_samples      = r_samples;
        n_phase        = r_phase;
        n_point        = r_point;
        n_low_acc      = r_low_acc;
        n_high_acc     = r_high_acc;
        n_level_q      = r_level_q;
        n_latched_high = r_latched_high;
        n_latch        = 1'b0;
        n_status       = r_running ? bdrs_pkg::ST_RUNNING : bdrs_pkg::ST_IDLE;
        unique case (bdrs_pkg::t_cmd'(i_cmd))
            bdrs_pkg::CMD_START: begin
                n_running      = 1'b1;
                n_samples      = '0;
                n_phase        = '0;
                n_point        = '0;
                n_low_acc      = r_low_start;
                n_high_acc     = r_high_start;
                n_level_q      = r_low_start;
                n_latched_high = 1'b0;
                n_latch        = 1'b1;
                n_status       = bdrs_pkg::ST_RUNNING;
            end
            bdrs_pkg::CMD_STOP: begin
                if (r_running) begin
                    n_running = 1'b0;
                    n_status  = bdrs_pkg::ST_STOPPED;
                end
            end
            bdrs_pkg::CMD_FRAME: begin
                if (r_running) begin
                    priority if (i_frame_rejected) begin
                        // overflowed frame is not counted
                        n_running = 1'b0;
                        n_status  = bdrs_pkg::ST_OVERFLOW;
                    end else if (w_step_open) begin
                        n_samples = w_count[COUNT_BITS-1:0];
                    end else if (w_last_step) begin
                        n_samples = w_count[COUNT_BITS-1:0];
                        n_running = 1'b0;
                        n_status  = bdrs_pkg::ST_DONE;
                    end else begin
                        n_samples      = '0;
                        n_phase        = w_phase_adv;
                        n_low_acc      = w_low_adv;
                        n_high_acc     = w_high_adv;
                        if (w_pair_end) begin
                            n_point = w_point_inc[COUNT_BITS-1:0];
                        end
                        // odd phase picks the high set
                        n_latched_high = w_phase_adv[0];
                        n_level_q      = w_phase_adv[0] ? w_high_adv : w_low_adv;
                        n_latch        = 1'b1;
                        n_status       = bdrs_pkg::ST_RUNNING;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_points <= COUNT_BITS'(1);
            r_measures    <= COUNT_BITS'(1);
            r_averages    <= COUNT_BITS'(1);
            r_low_start   <= '0;
            r_low_step    <= '0;
            r_high_start  <= '0;
            r_high_step   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdrs_pkg::CFG_RAMP_POINTS: r_ramp_points <= i_cfg_data[COUNT_BITS-1:0];
                bdrs_pkg::CFG_MEASURES:    r_measures    <= i_cfg_data[COUNT_BITS-1:0];
                bdrs_pkg::CFG_AVERAGES:    r_averages    <= i_cfg_data[COUNT_BITS-1:0];
                bdrs_pkg::CFG_LOW_START:   r_low_start   <= i_cfg_data[LEVEL_BITS-1:0];
                bdrs_pkg::CFG_LOW_STEP:    r_low_step    <= i_cfg_data[LEVEL_BITS-1:0];
                bdrs_pkg::CFG_HIGH_START:  r_high_start  <= i_cfg_data[LEVEL_BITS-1:0];
                bdrs_pkg::CFG_HIGH_STEP:   r_high_step   <= i_cfg_data[LEVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running      <= 1'b0;
            r_samples      <= '0;
            r_phase        <= '0;
            r_point        <= '0;
            r_low_acc      <= '0;
            r_high_acc     <= '0;
            r_level_q      <= '0;
            r_latched_high <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_running      <= n_running;
                r_samples      <= n_samples;
                r_phase        <= n_phase;
                r_point        <= n_point;
                r_low_acc      <= n_low_acc;
                r_high_acc     <= n_high_acc;
                r_level_q      <= n_level_q;
                r_latched_high <= n_latched_high;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    // result payload, loaded with every accepted word
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_latch      <= n_latch;
            r_level      <= n_level_q;
            r_ramp_index <= RIW'(n_point);
            r_is_high    <= n_latched_high;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_latch      = r_latch;
    assign o_level      = r_level;
    assign o_ramp_index = r_ramp_index;
    assign o_is_high    = r_is_high;
    assign o_status     = r_status;

`ifndef ASSERT_OFF
    a_start_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && (i_cmd == bdrs_pkg::CMD_START) |=>
            o_out_valid && o_latch && (o_status == bdrs_pkg::ST_RUNNING) &&
            (o_level == $past(r_low_start)) && !o_is_high)
        else $error("start word did not latch the first low level");

    a_idle_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && !r_running && (i_cmd != bdrs_pkg::CMD_START) |=>
            !r_running && !o_latch && (o_status == bdrs_pkg::ST_IDLE))
        else $error("non-start word changed an idle sequencer");

    a_latch_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_latch |-> (o_status == bdrs_pkg::ST_RUNNING) && r_running)
        else $error("latch reported outside a running sequence");

    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && r_running && (i_cmd == bdrs_pkg::CMD_FRAME) && i_frame_rejected |=>
            !r_running && (o_status == bdrs_pkg::ST_OVERFLOW) && !o_latch)
        else $error("rejected frame did not end the run");
`endif

endmodule
`default_nettype wire
